// ===== rtl/lor_pkg.sv =====
// Shared types and constants for the longest ones run tracker.
package lor_pkg;

  localparam int LEN_W           = 16;
  localparam int FLIPS_W         = 4;
  localparam int MAX_FLIPS_DEF   = 15;
  localparam int INDEX_WIDTH_DEF = 16;
  localparam int ADDR_W          = 1;
  localparam int DATA_W          = 32;

  localparam logic [LEN_W-1:0]  LEN_MAX       = '1;
  localparam logic [ADDR_W-1:0] REG_MAX_FLIPS = '0;

  typedef struct packed {
    logic [LEN_W-1:0] window_len;
    logic [LEN_W-1:0] best_len;
    logic             overflow;
  } lor_result_t;

endpackage

// ===== rtl/lor_cell.sv =====
// One slot of the zero position chain: holds the n-th most recent zero.
module lor_cell #(
  parameter int INDEX_WIDTH = lor_pkg::INDEX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   clear,
  input  logic                   shift,
  input  logic [INDEX_WIDTH-1:0] d_in,
  input  logic                   v_in,
  output logic [INDEX_WIDTH-1:0] d_q,
  output logic                   v_eff,
  output logic [INDEX_WIDTH-1:0] d_next,
  output logic                   v_next
);

  logic [INDEX_WIDTH-1:0] d;
  logic                   v;

  // a new sequence empties the slot before this bit is taken
  assign d_q    = d;
  assign v_eff  = v & ~clear;
  assign d_next = shift ? d_in : d;
  assign v_next = shift ? v_in : v_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (en) begin
      v <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d <= d_next;
    end
  end

endmodule

// ===== rtl/lor_outq.sv =====
// Result register with one skid slot between the datapath and the output port.
module lor_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lor_pkg::lor_result_t din,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output lor_pkg::lor_result_t dout
);

  lor_pkg::lor_result_t skid;
  logic                 skid_valid;
  logic                 take;

  assign take = out_valid & ~out_stall;
  assign full = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        dout <= skid;
      end
    end else if (push) begin
      if (out_valid && !take) begin
        skid <= din;
      end else begin
        dout <= din;
      end
    end
  end

endmodule

// ===== rtl/longest_ones_run_with_flips.sv =====
// Top level: sliding window of ones with up to max_flips zeros, one bit per transfer.
// Takes one bit per clock while in_stall is low and returns one result per bit. The positions
// of the most recent MAX_FLIPS+1 zeros sit in a shift chain of cells; a zero bit advances the
// chain, and max_flips picks the cell that marks the window start. The per-bit update (chain
// tap, one subtract, one compare) is combinational, and a result register with one skid slot
// lets input keep flowing while a result waits. max_flips is written through the APB port at
// address 0; the user must write it only while idle, which the block does not enforce. Values
// above MAX_FLIPS act as MAX_FLIPS. Positions saturate at 2^INDEX_WIDTH-1 and raise overflow.
module longest_ones_run_with_flips #(
  parameter int MAX_FLIPS   = lor_pkg::MAX_FLIPS_DEF,
  parameter int INDEX_WIDTH = lor_pkg::INDEX_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lor_pkg::ADDR_W-1:0] paddr,
  input  logic [lor_pkg::DATA_W-1:0] pwdata,
  output logic [lor_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       bit_value,
  input  logic                       seq_start,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lor_pkg::LEN_W-1:0]  window_len,
  output logic [lor_pkg::LEN_W-1:0]  best_len,
  output logic                       overflow
);

  localparam int DEPTH = MAX_FLIPS + 1;
  localparam int KW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LW    = INDEX_WIDTH + 1;
  localparam int CW    = (lor_pkg::FLIPS_W > KW ? lor_pkg::FLIPS_W : KW) + 2;
  localparam logic [INDEX_WIDTH-1:0] POS_MAX = '1;

  logic [lor_pkg::FLIPS_W-1:0] max_flips;
  logic [INDEX_WIDTH-1:0]      position;
  logic [INDEX_WIDTH-1:0]      position_next;
  logic [lor_pkg::LEN_W-1:0]   best;
  logic [lor_pkg::LEN_W-1:0]   best_next;
  logic                        ovf;
  logic                        ovf_next;

  logic                        acc;
  logic                        clear;
  logic                        shift;
  logic [INDEX_WIDTH-1:0]      pos_eff;
  logic [INDEX_WIDTH-1:0]      p;
  logic                        at_max;
  logic [KW-1:0]               k;
  logic [INDEX_WIDTH-1:0]      zsel;
  logic                        zvalid;
  logic [LW-1:0]               len;
  logic [lor_pkg::LEN_W-1:0]   len_sat;
  logic [lor_pkg::LEN_W-1:0]   best_eff;
  logic                        full;
  lor_pkg::lor_result_t        res;
  lor_pkg::lor_result_t        res_q;

  logic [INDEX_WIDTH-1:0] c_din   [DEPTH];
  logic                   c_vin   [DEPTH];
  logic [INDEX_WIDTH-1:0] c_dq    [DEPTH];
  logic                   c_veff  [DEPTH];
  logic [INDEX_WIDTH-1:0] c_dnext [DEPTH];
  logic                   c_vnext [DEPTH];

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == lor_pkg::REG_MAX_FLIPS) ?
                  lor_pkg::DATA_W'(max_flips) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_flips <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr == lor_pkg::REG_MAX_FLIPS) begin
      max_flips <= pwdata[lor_pkg::FLIPS_W-1:0];
    end
  end

  assign in_stall = full;
  assign acc      = in_valid & ~in_stall;
  assign clear    = acc & seq_start;
  assign shift    = acc & ~bit_value;

  // clamp the index of this bit at the counter limit
  assign pos_eff       = seq_start ? '0 : position;
  assign at_max        = (pos_eff == POS_MAX);
  assign p             = pos_eff;
  assign position_next = at_max ? POS_MAX : pos_eff + INDEX_WIDTH'(1);
  assign ovf_next      = (seq_start ? 1'b0 : ovf) | at_max;
  assign best_eff      = seq_start ? '0 : best;

  assign k = (CW'(max_flips) > CW'(MAX_FLIPS)) ? KW'(MAX_FLIPS) : KW'(max_flips);

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign c_din[gi] = p;
        assign c_vin[gi] = 1'b1;
      end else begin : g_link
        // a zero moves every stored position one cell down the chain
        assign c_din[gi] = c_dq[gi-1];
        assign c_vin[gi] = c_veff[gi-1];
      end
      lor_cell #(
        .INDEX_WIDTH(INDEX_WIDTH)
      ) u_cell (
        .clk    (clk),
        .rst    (rst),
        .en     (acc),
        .clear  (clear),
        .shift  (shift),
        .d_in   (c_din[gi]),
        .v_in   (c_vin[gi]),
        .d_q    (c_dq[gi]),
        .v_eff  (c_veff[gi]),
        .d_next (c_dnext[gi]),
        .v_next (c_vnext[gi])
      );
    end
  endgenerate

  // window start comes from the (k+1)-th most recent zero after this bit
  assign zsel   = c_dnext[k];
  assign zvalid = c_vnext[k];
  assign len    = zvalid ? LW'(p) - LW'(zsel) : LW'(p) + LW'(1);

  assign len_sat   = (len > LW'(lor_pkg::LEN_MAX)) ? lor_pkg::LEN_MAX
                                                   : lor_pkg::LEN_W'(len);
  assign best_next = (len_sat > best_eff) ? len_sat : best_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
      best     <= '0;
      ovf      <= 1'b0;
    end else if (acc) begin
      position <= position_next;
      best     <= best_next;
      ovf      <= ovf_next;
    end
  end

  always_comb begin
    res.window_len = len_sat;
    res.best_len   = best_next;
    res.overflow   = ovf_next;
  end

  lor_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (acc),
    .din       (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dout      (res_q)
  );

  assign window_len = res_q.window_len;
  assign best_len   = res_q.best_len;
  assign overflow   = res_q.overflow;

endmodule
